[sv/nca_pkg.sv]
// Shared types and constants for the nearest-centroid assignment block.
// Used by every module of the block except the generic RAM; depends on nothing else.
`default_nettype none

package nca_pkg;

	// Sizing of the centroid store and the datapath.
	localparam int MAX_CLUSTERS = 8;
	localparam int MAX_DIMS     = 16;
	localparam int COORD_BITS   = 16;

	localparam int CL_W    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int DIM_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int CNT_W   = $clog2(MAX_DIMS + 1);
	localparam int SQ_W    = 2 * COORD_BITS;
	localparam int ACC_W   = 37;
	localparam int DIST_W  = 36;
	localparam int COUNT_W = 16;

	// Request function codes; code 3 is unused and ignored.
	typedef enum logic [1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_POINT = 2'd1,
		FUNC_START = 2'd2
	} func_t;

	// Input request payload.
	typedef struct packed {
		logic [1:0]                   func;
		logic [2:0]                   cluster_sel;
		logic [3:0]                   dim_sel;
		logic signed [COORD_BITS-1:0] coord_value;
		logic                         last_coord;
		logic                         last_point;
		logic [3:0]                   prev_cluster;
	} in_item_t;

	// Result payload.
	typedef struct packed {
		logic [2:0]         nearest_cluster;
		logic               label_changed;
		logic [DIST_W-1:0]  min_distance_sq;
		logic [COUNT_W-1:0] cluster_count;
		logic [COUNT_W-1:0] change_total;
		logic               pass_done;
	} out_item_t;

	// Control carried from the front stage into the distance stages.
	typedef struct packed {
		logic                         point;
		logic                         start;
		logic                         acc_en;
		logic                         last_coord;
		logic                         last_point;
		logic [3:0]                   prev_cluster;
		logic signed [COORD_BITS-1:0] coord;
	} ctl_t;

	// Control carried through the selection and tally stages.
	typedef struct packed {
		logic       start;
		logic       res;
		logic       last_point;
		logic [3:0] prev_cluster;
	} tag_t;

	typedef logic [MAX_CLUSTERS-1:0][COORD_BITS-1:0] cent_vec_t;
	typedef logic [MAX_CLUSTERS-1:0][SQ_W-1:0]       sq_vec_t;
	typedef logic [MAX_CLUSTERS-1:0][ACC_W-1:0]      acc_vec_t;

endpackage

`default_nettype wire

[sv/nca_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the centroid store.
`default_nettype none

module nca_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; the output holds while re is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[sv/nca_accum.sv]
// Squared-difference lanes and per-cluster distance accumulators.
// Depends on nca_pkg; fed by the front stage and centroid RAMs of the top level.
`default_nettype none

module nca_accum (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire nca_pkg::ctl_t     ctl_s1,
	input  wire nca_pkg::cent_vec_t cent_rd,
	output nca_pkg::tag_t          tag_s3,
	output nca_pkg::acc_vec_t      dist_s3
);
	import nca_pkg::*;

	logic signed [COORD_BITS:0] diff [MAX_CLUSTERS];
	logic [COORD_BITS-1:0]      mag  [MAX_CLUSTERS];
	sq_vec_t                    sq_d;
	sq_vec_t                    sq_s2;
	ctl_t                       ctl_s2;
	acc_vec_t                   acc_q;
	acc_vec_t                   acc_nx;
	logic [ACC_W:0]             sum  [MAX_CLUSTERS];

	// One subtract and one square per cluster lane.
	always_comb begin
		for (int c = 0; c < MAX_CLUSTERS; c++) begin
			diff[c] = $signed({ctl_s1.coord[COORD_BITS-1], ctl_s1.coord})
				- $signed({cent_rd[c][COORD_BITS-1], cent_rd[c]});
			mag[c]  = diff[c][COORD_BITS] ? COORD_BITS'(-diff[c]) : diff[c][COORD_BITS-1:0];
			sq_d[c] = SQ_W'(mag[c]) * SQ_W'(mag[c]);
		end
	end

	// Saturating accumulate of the registered squares.
	always_comb begin
		for (int c = 0; c < MAX_CLUSTERS; c++) begin
			sum[c]    = {1'b0, acc_q[c]} + (ACC_W + 1)'(sq_s2[c]);
			acc_nx[c] = acc_q[c];
			if (ctl_s2.acc_en) begin
				acc_nx[c] = sum[c][ACC_W] ? {ACC_W{1'b1}} : sum[c][ACC_W-1:0];
			end
		end
	end

	// Control and accumulator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			tag_s3 <= '0;
			acc_q  <= '0;
		end else if (adv) begin
			ctl_s2              <= ctl_s1;
			tag_s3.start        <= ctl_s2.start;
			tag_s3.res          <= ctl_s2.point && ctl_s2.last_coord;
			tag_s3.last_point   <= ctl_s2.last_point;
			tag_s3.prev_cluster <= ctl_s2.prev_cluster;
			if (ctl_s2.start || (ctl_s2.point && ctl_s2.last_coord)) begin
				acc_q <= '0;
			end else if (ctl_s2.point) begin
				acc_q <= acc_nx;
			end
		end
	end

	// Payload registers: squares and the finished distances of a point.
	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s2   <= sq_d;
			dist_s3 <= acc_nx;
		end
	end

	// A start request always leaves the accumulators empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && ctl_s2.start) |=> (acc_q == '0))
		else $error("accumulators not cleared by start");

endmodule

`default_nettype wire

[sv/nca_argmin.sv]
// Registered minimum search over the active clusters' distances.
// Depends on nca_pkg; lowest index wins on equal distances.
`default_nettype none

module nca_argmin (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire logic [3:0]         clusters,
	input  wire nca_pkg::tag_t      tag_s3,
	input  wire nca_pkg::acc_vec_t  dist_s3,
	output nca_pkg::tag_t           tag_s4,
	output logic [nca_pkg::CL_W-1:0]  best_s4,
	output logic [nca_pkg::ACC_W-1:0] bestd_s4
);
	import nca_pkg::*;

	localparam int LVL  = CL_W;
	localparam int NPAD = 1 << LVL;

	logic [CL_W:0]  act_n;
	logic [ACC_W-1:0] cd [NPAD];
	logic [CL_W-1:0]  ci [NPAD];
	logic             cv [NPAD];

	// Active cluster count, clamped to one up to the store size.
	always_comb begin
		if (clusters == 4'd0) begin
			act_n = (CL_W + 1)'(1);
		end else if (int'(clusters) > MAX_CLUSTERS) begin
			act_n = (CL_W + 1)'(MAX_CLUSTERS);
		end else begin
			act_n = (CL_W + 1)'(clusters);
		end
	end

	// Pairwise tree; the lower slot keeps its entry unless the upper is strictly smaller.
	always_comb begin
		int a;
		int b;
		a = 0;
		b = 0;
		for (int n = 0; n < NPAD; n++) begin
			cd[n] = (n < MAX_CLUSTERS) ? dist_s3[n] : '0;
			ci[n] = CL_W'(n);
			cv[n] = (n < MAX_CLUSTERS) && (n < int'(act_n));
		end
		for (int l = 0; l < LVL; l++) begin
			for (int n = 0; n < (NPAD >> (l + 1)); n++) begin
				a = n << (l + 1);
				b = a + (1 << l);
				if (cv[b] && (!cv[a] || (cd[b] < cd[a]))) begin
					cd[a] = cd[b];
					ci[a] = ci[b];
					cv[a] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s4 <= '0;
		end else if (adv) begin
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			best_s4  <= ci[0];
			bestd_s4 <= cd[0];
		end
	end

endmodule

`default_nettype wire

[sv/nca_tally.sv]
// Per-pass cluster sizes, change count, result formatting and output skid.
// Depends on nca_pkg; driven by the minimum search stage.
`default_nettype none

module nca_tally (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire nca_pkg::tag_t         tag_s4,
	input  wire logic [nca_pkg::CL_W-1:0]  best_s4,
	input  wire logic [nca_pkg::ACC_W-1:0] bestd_s4,
	input  wire logic                  out_ready,
	output logic                       out_valid,
	output nca_pkg::out_item_t         out_data,
	output logic                       stall
);
	import nca_pkg::*;

	logic [MAX_CLUSTERS-1:0][COUNT_W-1:0] sizes_q;
	logic [COUNT_W-1:0] chg_q;
	logic [COUNT_W-1:0] sel_size;
	logic [COUNT_W-1:0] size_nx;
	logic [COUNT_W-1:0] chg_nx;
	logic               changed;
	logic               adv;
	logic               push;
	logic               pop;
	logic               take_skid;
	logic               load_out;
	logic               load_skid;
	logic               out_valid_q;
	logic               skid_valid_q;
	out_item_t          res_d;
	out_item_t          out_q;
	out_item_t          skid_q;

	assign adv   = !skid_valid_q;
	assign stall = skid_valid_q;
	assign push  = adv && tag_s4.res;
	assign pop   = out_valid_q && out_ready;

	// Saturating counter updates for the chosen cluster.
	always_comb begin
		sel_size = sizes_q[best_s4];
		changed  = int'(tag_s4.prev_cluster) != int'(best_s4);
		size_nx  = (&sel_size) ? sel_size : sel_size + 1'b1;
		chg_nx   = (changed && !(&chg_q)) ? chg_q + 1'b1 : chg_q;
	end

	// Result fields.
	always_comb begin
		res_d.nearest_cluster = 3'(best_s4);
		res_d.label_changed   = changed;
		res_d.min_distance_sq = bestd_s4[ACC_W-1] ? {DIST_W{1'b1}} : bestd_s4[DIST_W-1:0];
		res_d.cluster_count   = size_nx;
		res_d.change_total    = chg_nx;
		res_d.pass_done       = tag_s4.last_point;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sizes_q <= '0;
			chg_q   <= '0;
		end else if (adv) begin
			if (tag_s4.start) begin
				sizes_q <= '0;
				chg_q   <= '0;
			end else if (tag_s4.res) begin
				sizes_q[best_s4] <= size_nx;
				chg_q            <= chg_nx;
			end
		end
	end

	// Output register plus one skid entry.
	always_comb begin
		take_skid = pop && skid_valid_q;
		load_out  = push && (!out_valid_q || pop);
		load_skid = push && out_valid_q && !pop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q  <= skid_valid_q || push || (out_valid_q && !pop);
			skid_valid_q <= skid_valid_q ? !pop : load_skid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_skid) begin
			out_q <= skid_q;
		end else if (load_out) begin
			out_q <= res_d;
		end
		if (load_skid) begin
			skid_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The skid entry is only ever filled behind a waiting output.
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid without output valid");

	// A new result behind a stalled output lands in the skid entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && out_valid_q && !out_ready) |=> skid_valid_q)
		else $error("result lost behind stalled output");

endmodule

`default_nettype wire

[sv/nearest_centroid_assign.sv]
// K-means assignment step: centroid store, coordinate stream, nearest pick.
// Throughput: one request per cycle; the path is front/RAM read, square,
// accumulate, minimum search, tally. in_ready drops only while the output skid is full.
// Reset clears counters, accumulators and pipeline control; clusters_q resets to 8.
// The centroid RAMs are not cleared and hold unknown data until loaded.
`default_nettype none

module nearest_centroid_assign (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [3:0]         cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire nca_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output nca_pkg::out_item_t      out_data
);
	import nca_pkg::*;

	logic [3:0]       clusters_q;
	logic [CNT_W-1:0] cnt_q;
	logic             stall;
	logic             adv;
	logic             accept;
	logic             is_load;
	logic             is_point;
	logic             is_start;
	logic             load_ok;
	logic             acc_en;
	ctl_t             ctl_d;
	ctl_t             ctl_s1;
	cent_vec_t        cent_rd;
	tag_t             tag_s3;
	acc_vec_t         dist_s3;
	tag_t             tag_s4;
	logic [CL_W-1:0]  best_s4;
	logic [ACC_W-1:0] bestd_s4;

	assign adv      = !stall;
	assign in_ready = adv;
	assign accept   = in_valid && in_ready;

	// Request decode.
	always_comb begin
		is_load  = 1'b0;
		is_point = 1'b0;
		is_start = 1'b0;
		case (in_data.func)
			FUNC_LOAD:  is_load  = accept;
			FUNC_POINT: is_point = accept;
			FUNC_START: is_start = accept;
			default: ;
		endcase
		load_ok = is_load && (int'(in_data.cluster_sel) < MAX_CLUSTERS)
			&& (int'(in_data.dim_sel) < MAX_DIMS);
		acc_en  = cnt_q < CNT_W'(MAX_DIMS);
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clusters_q <= 4'd8;
		end else if (cfg_we) begin
			clusters_q <= cfg_data;
		end
	end

	// Coordinate counter of the point being streamed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (is_start || (is_point && in_data.last_coord)) begin
			cnt_q <= '0;
		end else if (is_point && acc_en) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Front pipeline register; bubbles carry neither point nor start.
	always_comb begin
		ctl_d.point        = is_point;
		ctl_d.start        = is_start;
		ctl_d.acc_en       = is_point && acc_en;
		ctl_d.last_coord   = in_data.last_coord;
		ctl_d.last_point   = in_data.last_point;
		ctl_d.prev_cluster = in_data.prev_cluster;
		ctl_d.coord        = in_data.coord_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_d;
		end
	end

	// One centroid RAM per cluster, all read at the current coordinate index.
	for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cent
		nca_ram #(
			.WIDTH(COORD_BITS),
			.DEPTH(MAX_DIMS)
		) u_ram (
			.clk   (clk),
			.we    (load_ok && (int'(in_data.cluster_sel) == g)),
			.waddr (DIM_W'(in_data.dim_sel)),
			.wdata (in_data.coord_value),
			.re    (adv),
			.raddr (cnt_q[DIM_W-1:0]),
			.rdata (cent_rd[g])
		);
	end

	nca_accum u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctl_s1  (ctl_s1),
		.cent_rd (cent_rd),
		.tag_s3  (tag_s3),
		.dist_s3 (dist_s3)
	);

	nca_argmin u_argmin (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.clusters (clusters_q),
		.tag_s3   (tag_s3),
		.dist_s3  (dist_s3),
		.tag_s4   (tag_s4),
		.best_s4  (best_s4),
		.bestd_s4 (bestd_s4)
	);

	nca_tally u_tally (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_s4    (tag_s4),
		.best_s4   (best_s4),
		.bestd_s4  (bestd_s4),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.stall     (stall)
	);

	// The coordinate counter never runs past the store depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_DIMS))
		else $error("coordinate counter past store depth");

endmodule

`default_nettype wire
